// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros used by the auto-pan controller.
// Clocked checks with and without a reset qualifier.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every rising edge, ignored while reset is asserted.
`define ASSERT_CLK(label, clk_sig, rst_n, prop, msg) \
	label: assert property (@(posedge clk_sig) disable iff (!rst_n) prop) else $error(msg);

// Check on every rising edge, including while reset is asserted.
`define ASSERT_ALL(label, clk_sig, prop, msg) \
	label: assert property (@(posedge clk_sig) prop) else $error(msg);

`endif

// ----- rtl/slap_pkg.sv -----
// ----------------------------------------------------------------------------
// slap_pkg
// Types and constants shared by the sine LFO auto-pan modules.
// ----------------------------------------------------------------------------
package slap_pkg;

	// Configuration port geometry.
	localparam int unsigned CFG_INDEX_W = 2;
	localparam int unsigned CFG_DATA_W  = 32;

	// Register indexes on the configuration port.
	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_PHASE_STEP    = 2'd0,
		REG_DEPTH_GAIN    = 2'd1,
		REG_CHANNEL_COUNT = 2'd2
	} reg_index_t;

	// Register reset values.
	localparam logic [31:0] PHASE_STEP_RESET    = 32'd89478;
	localparam logic [15:0] DEPTH_GAIN_RESET    = 16'd4096;
	localparam logic [1:0]  CHANNEL_COUNT_RESET = 2'd2;

	// Channel count codes; every other code scales both channels.
	localparam logic [1:0] CHAN_NONE = 2'd0;
	localparam logic [1:0] CHAN_MONO = 2'd1;

	// Fixed-point widths: pan is unsigned Q1.16 in [0, 1], gain is signed Q16.
	localparam int unsigned PAN_W  = 17;
	localparam int unsigned GAIN_W = 21;

	// Pi/2 in Q30, used to build the quarter-wave table.
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

	// Write request from the configuration port.
	typedef struct packed {
		logic                   en;
		logic [CFG_INDEX_W-1:0] index;
		logic [CFG_DATA_W-1:0]  data;
	} cfg_wr_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;    // capture a sample pair, look up pan, advance phase
		logic gain;    // multiply depth by pan, form both gains
		logic mul_l;   // scale the left sample
		logic mul_r;   // scale the right sample
		logic commit;  // write the result register
	} cmd_t;

endpackage

// ----- rtl/slap_ifs.sv -----
// ----------------------------------------------------------------------------
// slap stream interfaces
// Valid/ready channels for sample pairs in and scaled pairs out.
// ----------------------------------------------------------------------------

// Input channel: one left/right sample pair per request.
interface slap_sample_if #(
	parameter int unsigned SAMPLE_BITS = 24
) ();
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] left_in;
	logic signed [SAMPLE_BITS-1:0] right_in;

	modport source (output valid, output left_in, output right_in, input ready);
	modport sink (input valid, input left_in, input right_in, output ready);
endinterface

// Output channel: one scaled pair and a saturation flag per request.
interface slap_result_if #(
	parameter int unsigned SAMPLE_BITS = 24
) ();
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] left_out;
	logic signed [SAMPLE_BITS-1:0] right_out;
	logic                          clipped;

	modport source (output valid, output left_out, output right_out, output clipped,
		input ready);
	modport sink (input valid, input left_out, input right_out, input clipped,
		output ready);
endinterface

// ----- rtl/slap_dp.sv -----
// ----------------------------------------------------------------------------
// slap_dp
// Datapath: configuration registers, LFO phase, quarter-wave sine table,
// one shared signed multiplier, rounding, saturation and result register.
// ----------------------------------------------------------------------------
module slap_dp #(
	parameter int unsigned SAMPLE_BITS      = 24,
	parameter int unsigned SINE_TABLE_DEPTH = 256
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  slap_pkg::cfg_wr_t             cfg_wr,
	input  slap_pkg::cmd_t                cmd,
	input  logic signed [SAMPLE_BITS-1:0] left_in,
	input  logic signed [SAMPLE_BITS-1:0] right_in,
	output logic signed [SAMPLE_BITS-1:0] left_out,
	output logic signed [SAMPLE_BITS-1:0] right_out,
	output logic                          clipped
);
	import slap_pkg::*;

	// Table index width covers 0..SINE_TABLE_DEPTH inclusive.
	localparam int unsigned IDX_W  = $clog2(SINE_TABLE_DEPTH + 1);
	localparam int unsigned IPROD_W = 30 + IDX_W;
	// Multiplier operand A holds a sample or the pan value.
	localparam int unsigned OPA_W  = (SAMPLE_BITS > PAN_W + 1) ? SAMPLE_BITS : PAN_W + 1;
	localparam int unsigned PROD_W = OPA_W + GAIN_W;
	localparam int unsigned Y_W    = PROD_W - 16;

	// Quarter-wave sine in Q15, Taylor series in Q30, capped at unity.
	function automatic logic [15:0] sine_entry(input int unsigned i);
		logic [63:0] th;
		logic [63:0] th2;
		logic [63:0] term;
		logic [63:0] sum;
		logic [63:0] q;
		th   = (HALF_PI_Q30 * 64'(i)) / 64'(SINE_TABLE_DEPTH);
		th2  = (th * th) >> 30;
		term = th;
		sum  = th;
		term = ((term * th2) >> 30) / 64'd6;
		sum  = sum - term;
		term = ((term * th2) >> 30) / 64'd20;
		sum  = sum + term;
		term = ((term * th2) >> 30) / 64'd42;
		sum  = sum - term;
		term = ((term * th2) >> 30) / 64'd72;
		sum  = sum + term;
		term = ((term * th2) >> 30) / 64'd110;
		sum  = sum - term;
		term = ((term * th2) >> 30) / 64'd156;
		sum  = sum + term;
		term = ((term * th2) >> 30) / 64'd210;
		sum  = sum - term;
		q = (sum + 64'd16384) >> 15;
		if (q > 64'd32768) begin
			q = 64'd32768;
		end
		return q[15:0];
	endfunction

	// Constant quarter-wave table.
	logic [15:0] sine_rom [SINE_TABLE_DEPTH+1];
	for (genvar g = 0; g <= SINE_TABLE_DEPTH; g++) begin : g_rom
		assign sine_rom[g] = sine_entry(g);
	end

	// Configuration and LFO state.
	logic [31:0] phase_step_q;
	logic [15:0] depth_gain_q;
	logic [1:0]  channel_count_q;
	logic [31:0] phase_q;

	// Working registers for the item in flight.
	logic signed [SAMPLE_BITS-1:0] left_q;
	logic signed [SAMPLE_BITS-1:0] right_q;
	logic [PAN_W-1:0]              pan_q;
	logic signed [GAIN_W-1:0]      gain_l_q;
	logic signed [GAIN_W-1:0]      gain_r_q;
	logic signed [SAMPLE_BITS-1:0] left_res_q;
	logic                          clip_l_q;

	// Result register.
	logic signed [SAMPLE_BITS-1:0] left_out_q;
	logic signed [SAMPLE_BITS-1:0] right_out_q;
	logic                          clipped_q;

	// Sine lookup from the phase held before the step.
	logic [IPROD_W-1:0] idx_prod;
	logic [IDX_W-1:0]   idx;
	logic [IDX_W-1:0]   rom_addr;
	logic [15:0]        sine_mag;
	logic [PAN_W-1:0]   pan_next;

	always_comb begin
		idx_prod = IPROD_W'(phase_q[29:0]) * IPROD_W'(SINE_TABLE_DEPTH);
		idx      = idx_prod[30 +: IDX_W];
		rom_addr = phase_q[30] ? (IDX_W'(SINE_TABLE_DEPTH) - idx) : idx;
		sine_mag = sine_rom[rom_addr];
		pan_next = phase_q[31] ? (PAN_W'(32768) - PAN_W'(sine_mag))
			: (PAN_W'(32768) + PAN_W'(sine_mag));
	end

	// Shared multiplier with its operand select; it idles between items.
	logic signed [OPA_W-1:0]  op_a;
	logic signed [GAIN_W-1:0] op_b;
	logic signed [PROD_W-1:0] prod;

	always_comb begin
		op_a = '0;
		op_b = '0;
		if (cmd.gain) begin
			op_a = $signed(OPA_W'(pan_q));
			op_b = $signed(GAIN_W'(depth_gain_q));
		end else if (cmd.mul_l) begin
			op_a = OPA_W'(left_q);
			op_b = gain_l_q;
		end else if (cmd.mul_r) begin
			op_a = OPA_W'(right_q);
			op_b = gain_r_q;
		end
		prod = op_a * op_b;
	end

	// Gains from depth times pan; the right gain uses depth times (1 - pan)
	// written as depth * 2^16 minus the same product.
	logic [32:0]              dp_prod;
	logic [32:0]              m_l_sum;
	logic [32:0]              m_r_sum;
	logic signed [GAIN_W-1:0] gain_l_next;
	logic signed [GAIN_W-1:0] gain_r_next;

	always_comb begin
		dp_prod     = 33'(prod[31:0]);
		m_l_sum     = dp_prod + 33'd2048;
		m_r_sum     = 33'({depth_gain_q, 16'h0000}) - dp_prod + 33'd2048;
		gain_l_next = $signed(GAIN_W'(65536)) - $signed(GAIN_W'(m_l_sum[31:12]));
		gain_r_next = $signed(GAIN_W'(65536)) - $signed(GAIN_W'(m_r_sum[31:12]));
	end

	// Round to nearest with floor, then saturate to the sample width.
	logic signed [PROD_W-1:0]      rnd_sum;
	logic signed [Y_W-1:0]         y_full;
	logic                          y_ovf;
	logic signed [SAMPLE_BITS-1:0] y_sat;

	always_comb begin
		rnd_sum = prod + PROD_W'(32768);
		y_full  = Y_W'(rnd_sum >>> 16);
		y_ovf   = !((&y_full[Y_W-1:SAMPLE_BITS-1]) || !(|y_full[Y_W-1:SAMPLE_BITS-1]));
		if (!y_ovf) begin
			y_sat = y_full[SAMPLE_BITS-1:0];
		end else if (y_full[Y_W-1]) begin
			y_sat = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
		end else begin
			y_sat = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
		end
	end

	// Configuration registers and phase accumulator.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_step_q    <= PHASE_STEP_RESET;
			depth_gain_q    <= DEPTH_GAIN_RESET;
			channel_count_q <= CHANNEL_COUNT_RESET;
			phase_q         <= '0;
		end else begin
			if (cfg_wr.en) begin
				unique case (cfg_wr.index)
					REG_PHASE_STEP:    phase_step_q    <= cfg_wr.data[31:0];
					REG_DEPTH_GAIN:    depth_gain_q    <= cfg_wr.data[15:0];
					REG_CHANNEL_COUNT: channel_count_q <= cfg_wr.data[1:0];
					default: ;
				endcase
			end
			if (cmd.load) begin
				phase_q <= phase_q + phase_step_q;
			end
		end
	end

	// Working and result registers.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			left_q  <= left_in;
			right_q <= right_in;
			pan_q   <= pan_next;
		end
		if (cmd.gain) begin
			gain_l_q <= gain_l_next;
			gain_r_q <= gain_r_next;
		end
		if (cmd.mul_l) begin
			if (channel_count_q != CHAN_NONE) begin
				left_res_q <= y_sat;
				clip_l_q   <= y_ovf;
			end else begin
				left_res_q <= left_q;
				clip_l_q   <= 1'b0;
			end
		end
		if (cmd.commit) begin
			left_out_q <= left_res_q;
			if (channel_count_q != CHAN_NONE && channel_count_q != CHAN_MONO) begin
				right_out_q <= y_sat;
				clipped_q   <= clip_l_q | y_ovf;
			end else begin
				right_out_q <= right_q;
				clipped_q   <= clip_l_q;
			end
		end
	end

	assign left_out  = left_out_q;
	assign right_out = right_out_q;
	assign clipped   = clipped_q;

endmodule

// ----- rtl/slap_ctrl.sv -----
// ----------------------------------------------------------------------------
// slap_ctrl
// Controller: sequences lookup, gain and the two sample multiplies, and
// owns the valid bit of the result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module slap_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	output slap_pkg::cmd_t cmd
);
	import slap_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_GAIN,
		ST_MUL_L,
		ST_MUL_R
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	// The result register can take a new pair when empty or being drained.
	assign out_free = !out_valid_q || out_ready;

	// Commands decoded from the state.
	always_comb begin
		cmd.load   = (state_q == ST_IDLE) && in_valid;
		cmd.gain   = (state_q == ST_GAIN);
		cmd.mul_l  = (state_q == ST_MUL_L);
		cmd.mul_r  = (state_q == ST_MUL_R);
		cmd.commit = (state_q == ST_MUL_R) && out_free;
	end

	// State and result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			// A commit refills the result register; otherwise a drain empties it.
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_GAIN;
					end
				end
				ST_GAIN: begin
					state_q <= ST_MUL_L;
				end
				ST_MUL_L: begin
					state_q <= ST_MUL_R;
				end
				ST_MUL_R: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	// A captured pair always moves on to the gain step.
	`ASSERT_CLK(a_load_to_gain, clk, arst_n, cmd.load |=> (state_q == ST_GAIN),
		"accepted pair did not enter the gain step")
	// Writing the result register always raises its valid.
	`ASSERT_CLK(a_commit_valid, clk, arst_n, cmd.commit |=> out_valid_q,
		"committed result not offered")
	// A full, stalled result register holds the last step back.
	`ASSERT_CLK(a_stall_holds, clk, arst_n,
		(state_q == ST_MUL_R && out_valid_q && !out_ready) |=> (state_q == ST_MUL_R),
		"result overwritten while output stalled")
	// Nothing is in flight or offered while reset is held.
	`ASSERT_ALL(a_reset_idle, clk, (!arst_n) |-> (state_q == ST_IDLE && !out_valid_q),
		"controller not idle during reset")

endmodule

// ----- rtl/sine_lfo_stereo_autopan.sv -----
// ----------------------------------------------------------------------------
// sine_lfo_stereo_autopan
// Stereo auto-pan driven by a sine LFO with a 32-bit phase accumulator.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Payload                          Request moves
//  samples   in         left_in, right_in                one sample pair
//  results   out        left_out, right_out, clipped     one scaled pair
//  wr_*      in         wr_index, wr_data                one register write
//
// A pair goes through the sine lookup and phase advance, then through
// three passes of the one shared multiplier (depth times pan, left
// sample times gain, right sample times gain), in that order.
// samples.ready is high only while no pair is in flight.
// A finished pair waits in the result register; if that register is still
// full at the last step, the last step waits until it drains.
// arst_n clears the sequencer and phase and loads the register defaults.
// ----------------------------------------------------------------------------
module sine_lfo_stereo_autopan #(
	parameter int unsigned SAMPLE_BITS      = 24,
	parameter int unsigned SINE_TABLE_DEPTH = 256
) (
	input  logic                                clk,
	input  logic                                arst_n,
	slap_sample_if.sink                         samples,
	slap_result_if.source                       results,
	input  logic                                wr_en,
	input  logic [slap_pkg::CFG_INDEX_W-1:0]    wr_index,
	input  logic [slap_pkg::CFG_DATA_W-1:0]     wr_data
);
	import slap_pkg::*;

	cmd_t    cmd;
	cfg_wr_t cfg_wr;

	// Bundle the configuration write.
	always_comb begin
		cfg_wr.en    = wr_en;
		cfg_wr.index = wr_index;
		cfg_wr.data  = wr_data;
	end

	// Sequencer.
	slap_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (samples.valid),
		.in_ready  (samples.ready),
		.out_valid (results.valid),
		.out_ready (results.ready),
		.cmd       (cmd)
	);

	// Arithmetic and state.
	slap_dp #(
		.SAMPLE_BITS      (SAMPLE_BITS),
		.SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr    (cfg_wr),
		.cmd       (cmd),
		.left_in   (samples.left_in),
		.right_in  (samples.right_in),
		.left_out  (results.left_out),
		.right_out (results.right_out),
		.clipped   (results.clipped)
	);

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the sine LFO stereo auto-pan. A scoreboard class
// tracks the LFO phase and the register settings from the writes and the
// sample pairs that it sees on the ports. For each accepted pair it predicts
// the scaled pair and the clip flag. Each result request is then compared
// field by field, in order. Directed pairs cover the sample extremes, every
// channel mode and saturation. Random phases follow with changing register
// settings and changing amounts of idling on both channels.
// ----------------------------------------------------------------------------
module testbench;
	import slap_pkg::*;

	localparam int unsigned SAMPLE_BITS  = 24;
	localparam int unsigned TABLE_DEPTH  = 256;
	localparam int unsigned SETTLE_CYCLES = 8;
	localparam int unsigned PHASES       = 12;
	localparam int unsigned PHASE_ITEMS  = 110;
	localparam int unsigned HOLD_CYCLES  = 300;

	// Channel codes above mono, and the register index that has no register.
	localparam logic [1:0] CHAN_STEREO = 2'd2;
	localparam logic [1:0] CHAN_EXTRA  = 2'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 2'd3;

	localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = 24'sh7FFFFF;
	localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = 24'sh800000;

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;

	typedef struct packed {
		sample_t left;
		sample_t right;
		logic    clip;
	} scaled_pair_t;

	// Predicts the auto-pan and holds the scaled pairs still to come.
	class autopan_scoreboard;
		logic [15:0]  quarter_sine [0:TABLE_DEPTH];
		logic [31:0]  step_reg;
		logic [15:0]  depth_reg;
		logic [1:0]   chan_reg;
		logic [31:0]  lfo_phase;
		scaled_pair_t pending_pairs [$];
		int           errors;
		int           pairs_in;
		int           pairs_out;
		int           clip_count;
		int           mode_count [4];

		function new();
			longint unsigned th, th2, term, sum, q, k;
			for (int i = 0; i <= TABLE_DEPTH; i++) begin
				th = (HALF_PI_Q30 * longint'(i)) / longint'(TABLE_DEPTH);
				th2 = (th * th) >> 30;
				term = th;
				sum = th;
				// Taylor series of the sine, each term truncated.
				for (k = 1; k <= 7; k++) begin
					term = (term * th2) >> 30;
					term = term / ((2 * k) * (2 * k + 1));
					if (k[0])
						sum = sum - term;
					else
						sum = sum + term;
				end
				q = (sum + 64'd16384) >> 15;
				if (q > 64'd32768)
					q = 64'd32768;
				quarter_sine[i] = q[15:0];
			end
			step_reg  = PHASE_STEP_RESET;
			depth_reg = DEPTH_GAIN_RESET;
			chan_reg  = CHANNEL_COUNT_RESET;
			lfo_phase = '0;
			errors = 0;
			pairs_in = 0;
			pairs_out = 0;
			clip_count = 0;
			foreach (mode_count[i])
				mode_count[i] = 0;
		endfunction

		function void note_config(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_PHASE_STEP:    step_reg  = data;
				REG_DEPTH_GAIN:    depth_reg = data[15:0];
				REG_CHANNEL_COUNT: chan_reg  = data[1:0];
				default: ;
			endcase
		endfunction

		// Sine of the phase in Q1.15 from the quarter-wave table.
		function longint lfo_sine(logic [31:0] ph);
			longint unsigned idx;
			longint v;
			idx = (longint'(ph[29:0]) * TABLE_DEPTH) >> 30;
			if (idx >= TABLE_DEPTH)
				idx = TABLE_DEPTH - 1;
			if (ph[30])
				v = quarter_sine[TABLE_DEPTH - idx];
			else
				v = quarter_sine[idx];
			return ph[31] ? -v : v;
		endfunction

		// Scales one sample by 1 - depth * p, rounds and saturates it.
		function sample_t apply_gain(longint x, longint p, inout logic clip);
			longint gain, y;
			gain = 65536 - ((longint'(depth_reg) * p + 2048) >>> 12);
			y = (x * gain + 32768) >>> 16;
			if (y > longint'(SAMPLE_MAX)) begin
				clip = 1'b1;
				y = SAMPLE_MAX;
			end else if (y < longint'(SAMPLE_MIN)) begin
				clip = 1'b1;
				y = SAMPLE_MIN;
			end
			return y[SAMPLE_BITS-1:0];
		endfunction

		function void note_pair(sample_t left, sample_t right);
			scaled_pair_t res;
			longint pan;
			pan = lfo_sine(lfo_phase) + 32768;
			lfo_phase = lfo_phase + step_reg;
			res.left = left;
			res.right = right;
			res.clip = 1'b0;
			if (chan_reg >= CHAN_MONO)
				res.left = apply_gain(longint'(left), pan, res.clip);
			if (chan_reg >= CHAN_STEREO)
				res.right = apply_gain(longint'(right), 65536 - pan, res.clip);
			pending_pairs.push_back(res);
			pairs_in++;
			mode_count[chan_reg]++;
		endfunction

		function void check_result(sample_t left, sample_t right, logic clip);
			scaled_pair_t exp_pair;
			if (pending_pairs.size() == 0) begin
				$error("result request with no pair outstanding: left_out %0d right_out %0d",
					left, right);
				errors++;
				return;
			end
			exp_pair = pending_pairs.pop_front();
			pairs_out++;
			if (exp_pair.clip)
				clip_count++;
			if (left !== exp_pair.left) begin
				$error("left_out: expected %0d, actual %0d", exp_pair.left, left);
				errors++;
			end
			if (right !== exp_pair.right) begin
				$error("right_out: expected %0d, actual %0d", exp_pair.right, right);
				errors++;
			end
			if (clip !== exp_pair.clip) begin
				$error("clipped: expected %0d, actual %0d", exp_pair.clip, clip);
				errors++;
			end
		endfunction

		function int outstanding();
			return pending_pairs.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic wr_en;
	logic [CFG_INDEX_W-1:0] wr_index;
	logic [CFG_DATA_W-1:0]  wr_data;

	slap_sample_if #(.SAMPLE_BITS(SAMPLE_BITS)) sample_ch ();
	slap_result_if #(.SAMPLE_BITS(SAMPLE_BITS)) result_ch ();

	autopan_scoreboard sb;
	int send_idle_pct;
	int recv_stall_pct;
	int hold_left;

	sine_lfo_stereo_autopan #(
		.SAMPLE_BITS(SAMPLE_BITS),
		.SINE_TABLE_DEPTH(TABLE_DEPTH)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.samples(sample_ch),
		.results(result_ch),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data)
	);

	// Clock, 12 ns period.
	initial clk = 1'b0;
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Run limit.
	initial begin
		#4_000_000;
		$display("FAILURE");
		$finish;
	end

	// Result receiver: random stalls, or a long hold-off while one is requested.
	initial begin
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				result_ch.ready <= 1'b0;
				hold_left = hold_left - 1;
			end else begin
				result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// Port monitor: register writes, accepted pairs and accepted results.
	always @(posedge clk) begin
		if (arst_n && sb != null) begin
			if (wr_en)
				sb.note_config(wr_index, wr_data);
			if (sample_ch.valid && sample_ch.ready)
				sb.note_pair(sample_ch.left_in, sample_ch.right_in);
			if (result_ch.valid && result_ch.ready)
				sb.check_result(result_ch.left_out, result_ch.right_out, result_ch.clipped);
		end
	end

	// Offers one pair, after a random gap, and waits until it is accepted.
	task automatic push_pair(input sample_t left, input sample_t right);
		if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			sample_ch.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		sample_ch.valid    <= 1'b1;
		sample_ch.left_in  <= left;
		sample_ch.right_in <= right;
		do @(posedge clk); while (!sample_ch.ready);
	endtask

	// Stops offering and waits until every scaled pair has come back.
	task automatic drain_results();
		sample_ch.valid <= 1'b0;
		do @(posedge clk); while (sb.outstanding() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= data;
		@(posedge clk);
		wr_en <= 1'b0;
		@(posedge clk);
	endtask

	// Writes all three registers; the bits above each register are random.
	task automatic set_registers(input logic [31:0] step, input logic [15:0] depth,
		input logic [1:0] chan);
		logic [31:0] fill;
		fill = $urandom;
		write_reg(REG_PHASE_STEP, step);
		write_reg(REG_DEPTH_GAIN, {fill[31:16], depth});
		write_reg(REG_CHANNEL_COUNT, {fill[31:2], chan});
	endtask

	// Random sample: mostly full range, with extremes and small values mixed in.
	function automatic sample_t pick_sample();
		logic [31:0] raw;
		raw = $urandom;
		case ($urandom_range(7))
			0: return SAMPLE_MAX;
			1: return SAMPLE_MIN;
			2: return sample_t'($signed({1'b0, raw[8:0]}) - 256);
			default: return raw[SAMPLE_BITS-1:0];
		endcase
	endfunction

	initial begin
		sample_t edge_left [6];
		sample_t edge_right [6];
		logic [31:0] step;
		logic [15:0] depth;
		logic [1:0] chan;
		logic [1:0] chan_pick [6];

		sb = new();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_left = 0;
		arst_n <= 1'b0;
		wr_en <= 1'b0;
		wr_index <= REG_PHASE_STEP;
		wr_data <= '0;
		sample_ch.valid <= 1'b0;
		sample_ch.left_in <= '0;
		sample_ch.right_in <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		edge_left  = '{SAMPLE_MAX, SAMPLE_MIN, 24'sd0, SAMPLE_MAX, SAMPLE_MIN, -24'sd1};
		edge_right = '{SAMPLE_MAX, SAMPLE_MIN, 24'sd0, SAMPLE_MIN, SAMPLE_MAX, 24'sd1};

		// Directed: sample extremes at the reset settings.
		for (int i = 0; i < 6; i++)
			push_pair(edge_left[i], edge_right[i]);
		drain_results();

		// Quarter-turn steps through every quadrant with a depth that saturates.
		set_registers(32'h4000_0000, 16'd40960, CHAN_STEREO);
		for (int i = 0; i < 6; i++)
			push_pair(edge_left[i], edge_right[i]);
		drain_results();

		// Mono: right passes through and never clips.
		write_reg(REG_CHANNEL_COUNT, {30'd0, CHAN_MONO});
		for (int i = 0; i < 4; i++)
			push_pair(edge_left[i], edge_right[i]);
		drain_results();

		// No channels, plus a write to the index that holds no register.
		write_reg(REG_CHANNEL_COUNT, {30'd0, CHAN_NONE});
		write_reg(REG_SPARE, $urandom);
		for (int i = 0; i < 3; i++)
			push_pair(edge_left[i], edge_right[i]);
		drain_results();

		// Channel code above stereo, deepest depth, largest step.
		set_registers(32'hFFFF_FFFF, 16'hFFFF, CHAN_EXTRA);
		for (int i = 0; i < 3; i++)
			push_pair(edge_left[i], edge_right[i]);
		drain_results();

		// Zero depth and a frozen phase.
		set_registers(32'd0, 16'd0, CHAN_STEREO);
		for (int i = 3; i < 6; i++)
			push_pair(edge_left[i], edge_right[i]);
		drain_results();

		// Random phases, each with fresh settings and its own idling mix.
		chan_pick = '{CHAN_STEREO, CHAN_STEREO, CHAN_MONO, CHAN_EXTRA, CHAN_NONE, CHAN_STEREO};
		for (int ph = 0; ph < PHASES; ph++) begin
			case ($urandom_range(5))
				0: step = 32'd0;
				1: step = 32'hFFFF_FFFF;
				2: step = 32'h8000_0000;
				3: step = $urandom_range(1, 2_000_000);
				default: step = $urandom;
			endcase
			case ($urandom_range(6))
				0: depth = 16'd410;
				1: depth = 16'd40960;
				2: depth = 16'd0;
				3: depth = 16'hFFFF;
				4: depth = DEPTH_GAIN_RESET;
				5: depth = $urandom;
				default: depth = $urandom_range(410, 40960);
			endcase
			chan = chan_pick[$urandom_range(5)];
			set_registers(step, depth, chan);

			case (ph % 4)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct = 70;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = 70;
				end
				default: begin
					send_idle_pct = 8;
					recv_stall_pct = 8;
				end
			endcase
			// Once, hold the results back so the block backs up into its input.
			if (ph == 4)
				hold_left = HOLD_CYCLES;

			for (int n = 0; n < PHASE_ITEMS; n++)
				push_pair(pick_sample(), pick_sample());
			drain_results();
		end

		sb.errors = sb.errors + sb.outstanding();
		$display("Checked %0d of %0d sample pairs, %0d with saturation.",
			sb.pairs_out, sb.pairs_in, sb.pairs_in == 0 ? 0 : sb.clip_count);
		$display("Pairs per channel mode: none %0d, mono %0d, stereo %0d, above stereo %0d.",
			sb.mode_count[0], sb.mode_count[1], sb.mode_count[2], sb.mode_count[3]);
		if (sb.errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// ----- sine_lfo_stereo_autopan.f -----
+incdir+rtl
rtl/slap_pkg.sv
rtl/slap_ifs.sv
rtl/slap_dp.sv
rtl/slap_ctrl.sv
rtl/sine_lfo_stereo_autopan.sv
bench/testbench.sv
